// File: src/lis_pkg.sv
`timescale 1ns / 1ps

package lis_pkg;

    // Default sizing
    localparam int DEF_MAX_ENTRIES = 256;
    localparam int DEF_COMP_BITS   = 24;

    // Fixed field widths
    localparam int POS_BITS    = 18;  // signed Q2.16 position
    localparam int FRAC_BITS   = 16;  // fraction bits of position and weight
    localparam int CFG_BITS    = 9;   // entries_in_use register
    localparam int IDX_IN_BITS = 8;   // entry_index field
    localparam int NUM_COMPS   = 4;

    localparam logic [CFG_BITS-1:0] ENTRIES_RESET = 9'd256;

    // Transaction modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

endpackage

// File: src/lis_addr.sv
`timescale 1ns / 1ps

module lis_addr
    import lis_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int IDX_BITS = $clog2(MAX_ENTRIES)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [CFG_BITS-1:0]        entries_in_use,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [POS_BITS-1:0] sample_pos,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [IDX_BITS-1:0]        out_i0,
    output logic [IDX_BITS-1:0]        out_i1,
    output logic [FRAC_BITS-1:0]       out_t
);

    localparam int NW = (IDX_BITS + 1 > CFG_BITS) ? IDX_BITS + 1 : CFG_BITS;
    localparam int XW = FRAC_BITS + 1 + IDX_BITS;
    localparam logic signed [POS_BITS-1:0] POS_ONE = POS_BITS'(1 << FRAC_BITS);

    logic [FRAC_BITS:0]  up;
    logic [NW-1:0]       n_wide;
    logic [IDX_BITS-1:0] nm1;
    logic [XW-1:0]       x_next;
    logic [XW-1:0]       x_reg;
    logic [IDX_BITS-1:0] nm1_reg;
    logic                valid_reg;

    // Clamp position to 0..1
    always_comb begin
        if (sample_pos < 0) begin
            up = '0;
        end else if (sample_pos > POS_ONE) begin
            up = (FRAC_BITS + 1)'(POS_ONE);
        end else begin
            up = sample_pos[FRAC_BITS:0];
        end
    end

    // Entries in use limited to 1..MAX_ENTRIES
    always_comb begin
        n_wide = NW'(entries_in_use);
        if (n_wide == '0) begin
            n_wide = NW'(1);
        end else if (n_wide > NW'(MAX_ENTRIES)) begin
            n_wide = NW'(MAX_ENTRIES);
        end
        nm1 = IDX_BITS'(n_wide - NW'(1));
    end

    assign x_next   = XW'(up) * XW'(nm1);
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg   <= x_next;
            nm1_reg <= nm1;
        end
    end

    // Integer part picks the span; upper entry capped at the last one
    assign out_i0    = x_reg[FRAC_BITS +: IDX_BITS];
    assign out_i1    = (out_i0 == nm1_reg) ? out_i0 : out_i0 + IDX_BITS'(1);
    assign out_t     = x_reg[FRAC_BITS-1:0];
    assign out_valid = valid_reg;

endmodule

// File: src/lis_store.sv
`timescale 1ns / 1ps

module lis_store
    import lis_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int COMP_BITS   = DEF_COMP_BITS,
    localparam int IDX_BITS = $clog2(MAX_ENTRIES),
    localparam int WORD_BITS = NUM_COMPS * COMP_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [IDX_IN_BITS-1:0] wr_addr,
    input  logic [WORD_BITS-1:0]   wr_data,
    input  logic                   rd_valid,
    output logic                   rd_ready,
    input  logic [IDX_BITS-1:0]    rd_i0,
    input  logic [IDX_BITS-1:0]    rd_i1,
    input  logic [FRAC_BITS-1:0]   rd_t,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WORD_BITS-1:0]   out_a,
    output logic [WORD_BITS-1:0]   out_b,
    output logic [FRAC_BITS-1:0]   out_t
);

    // One spare bit so the table size itself fits in the compare
    localparam int WIDX = ((IDX_BITS > IDX_IN_BITS) ? IDX_BITS : IDX_IN_BITS) + 1;

    logic [WORD_BITS-1:0] mem [MAX_ENTRIES];
    logic [WIDX-1:0]      waddr_wide;
    logic                 wr_ok;
    logic                 rd_fire;
    logic                 valid_reg;

    // Writes past the table are dropped
    assign waddr_wide = WIDX'(wr_addr);
    assign wr_ok      = wr_en && (waddr_wide < WIDX'(MAX_ENTRIES));
    assign rd_ready   = !valid_reg || out_ready;
    assign rd_fire    = rd_valid && rd_ready;

    // One write port, two registered read ports; same-edge read sees old data
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[waddr_wide[IDX_BITS-1:0]] <= wr_data;
        end
        if (rd_fire) begin
            out_a <= mem[rd_i0];
            out_b <= mem[rd_i1];
            out_t <= rd_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rd_ready) begin
            valid_reg <= rd_valid;
        end
    end

    assign out_valid = valid_reg;

endmodule

// File: src/lis_blend.sv
`timescale 1ns / 1ps

module lis_blend
    import lis_pkg::*;
#(
    parameter int COMP_BITS = DEF_COMP_BITS,
    localparam int WORD_BITS = NUM_COMPS * COMP_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_BITS-1:0] in_a,
    input  logic [WORD_BITS-1:0] in_b,
    input  logic [FRAC_BITS-1:0] in_t,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_BITS-1:0] out_data
);

    localparam int DW = COMP_BITS + 1;
    localparam int PW = COMP_BITS + FRAC_BITS + 2;
    localparam int SW = COMP_BITS + 2;

    logic signed [DW-1:0]        d_reg  [NUM_COMPS];
    logic signed [COMP_BITS-1:0] a3_reg [NUM_COMPS];
    logic [FRAC_BITS-1:0]        t3_reg;
    logic signed [PW-1:0]        p_reg  [NUM_COMPS];
    logic signed [COMP_BITS-1:0] a4_reg [NUM_COMPS];
    logic [WORD_BITS-1:0]        out_reg;
    logic                        v3_reg, v4_reg, vo_reg;
    logic                        r3, r4, ro;

    assign ro       = !vo_reg || out_ready;
    assign r4       = !v4_reg || ro;
    assign r3       = !v3_reg || r4;
    assign in_ready = r3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (r3) begin
                v3_reg <= in_valid;
            end
            if (r4) begin
                v4_reg <= v3_reg;
            end
            if (ro) begin
                vo_reg <= v4_reg;
            end
        end
    end

    // Difference stage: result = a + floor((b - a) * t / 2^16)
    always_ff @(posedge aclk) begin
        if (r3 && in_valid) begin
            for (int k = 0; k < NUM_COMPS; k++) begin
                d_reg[k]  <= DW'($signed(in_b[k*COMP_BITS +: COMP_BITS]))
                           - DW'($signed(in_a[k*COMP_BITS +: COMP_BITS]));
                a3_reg[k] <= $signed(in_a[k*COMP_BITS +: COMP_BITS]);
            end
            t3_reg <= in_t;
        end
    end

    // Weight multiply
    always_ff @(posedge aclk) begin
        if (r4 && v3_reg) begin
            for (int k = 0; k < NUM_COMPS; k++) begin
                p_reg[k]  <= PW'(d_reg[k]) * PW'($signed({1'b0, t3_reg}));
                a4_reg[k] <= a3_reg[k];
            end
        end
    end

    // Add base, arithmetic shift floors toward minus infinity
    always_ff @(posedge aclk) begin
        if (ro && v4_reg) begin
            for (int k = 0; k < NUM_COMPS; k++) begin
                out_reg[k*COMP_BITS +: COMP_BITS] <=
                    COMP_BITS'(SW'(a4_reg[k]) + SW'(p_reg[k] >>> FRAC_BITS));
            end
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = out_reg;

endmodule

// File: src/lut_linear_interp_sampler.sv
`timescale 1ns / 1ps
// Four-component lookup table with linear interpolation.
// Input channel (s_valid/s_ready): s_mode selects the transaction kind.
//   Write (mode 0) stores s_write_c0..c3 at s_entry_index; no result.
//   Sample (mode 1) clamps s_sample_pos (Q2.16) to 0..1, scales it by
//   entries_in_use - 1 and blends the two neighboring entries.
// Result channel (m_valid/m_ready): m_out_c0..c3, one per sample, in order.
// Configuration: cfg_wr_en/cfg_wr_data load entries_in_use; write it only
// while no sample is in flight.
// Pipeline: a sample is registered in turn by the scale, table read,
// difference, multiply and sum/output register stages.
// Throughput: one transaction per cycle unless m_ready stalls it, set by the
// two read ports of the entry memory and the fully pipelined blend path.
// Stall: stages hold their data and bubbles collapse, so input is taken as
// long as some stage ahead has room; with m_ready high s_ready is high.
// Reset: pipeline valids clear and entries_in_use returns to 256. Table
// contents are not cleared; sample only spans whose entries were written.

module lut_linear_interp_sampler
    import lis_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int COMP_BITS   = DEF_COMP_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_BITS-1:0]         cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [IDX_IN_BITS-1:0]      s_entry_index,
    input  logic signed [COMP_BITS-1:0] s_write_c0,
    input  logic signed [COMP_BITS-1:0] s_write_c1,
    input  logic signed [COMP_BITS-1:0] s_write_c2,
    input  logic signed [COMP_BITS-1:0] s_write_c3,
    input  logic signed [POS_BITS-1:0]  s_sample_pos,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [COMP_BITS-1:0] m_out_c0,
    output logic signed [COMP_BITS-1:0] m_out_c1,
    output logic signed [COMP_BITS-1:0] m_out_c2,
    output logic signed [COMP_BITS-1:0] m_out_c3
);

    localparam int IDX_BITS  = $clog2(MAX_ENTRIES);
    localparam int WORD_BITS = NUM_COMPS * COMP_BITS;

    logic [CFG_BITS-1:0]  entries_reg;
    logic                 addr_in_valid;
    logic                 addr_valid, addr_ready;
    logic [IDX_BITS-1:0]  addr_i0, addr_i1;
    logic [FRAC_BITS-1:0] addr_t;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_valid, rd_ready;
    logic [WORD_BITS-1:0] rd_a, rd_b;
    logic [FRAC_BITS-1:0] rd_t;
    logic                 blend_ready;
    logic [WORD_BITS-1:0] res_data;

    // Table size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= ENTRIES_RESET;
        end else if (cfg_wr_en) begin
            entries_reg <= cfg_wr_data;
        end
    end

    // Writes share acceptance with samples so table order follows the stream
    assign s_ready       = addr_ready;
    assign addr_in_valid = s_valid && (s_mode == MODE_SAMPLE);
    assign wr_en         = s_valid && s_ready && (s_mode == MODE_WRITE);
    assign wr_data       = {s_write_c3, s_write_c2, s_write_c1, s_write_c0};

    lis_addr #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_addr (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .entries_in_use (entries_reg),
        .in_valid       (addr_in_valid),
        .in_ready       (addr_ready),
        .sample_pos     (s_sample_pos),
        .out_valid      (addr_valid),
        .out_ready      (rd_ready),
        .out_i0         (addr_i0),
        .out_i1         (addr_i1),
        .out_t          (addr_t)
    );

    lis_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COMP_BITS   (COMP_BITS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (s_entry_index),
        .wr_data   (wr_data),
        .rd_valid  (addr_valid),
        .rd_ready  (rd_ready),
        .rd_i0     (addr_i0),
        .rd_i1     (addr_i1),
        .rd_t      (addr_t),
        .out_valid (rd_valid),
        .out_ready (blend_ready),
        .out_a     (rd_a),
        .out_b     (rd_b),
        .out_t     (rd_t)
    );

    lis_blend #(
        .COMP_BITS (COMP_BITS)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid),
        .in_ready  (blend_ready),
        .in_a      (rd_a),
        .in_b      (rd_b),
        .in_t      (rd_t),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_data)
    );

    assign m_out_c0 = res_data[0*COMP_BITS +: COMP_BITS];
    assign m_out_c1 = res_data[1*COMP_BITS +: COMP_BITS];
    assign m_out_c2 = res_data[2*COMP_BITS +: COMP_BITS];
    assign m_out_c3 = res_data[3*COMP_BITS +: COMP_BITS];

endmodule

// File: src/lis_checker.sv
`timescale 1ns / 1ps

module lis_checker
    import lis_pkg::*;
#(
    parameter int COMP_BITS = DEF_COMP_BITS
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [COMP_BITS-1:0] m_out_c0,
    input logic signed [COMP_BITS-1:0] m_out_c1,
    input logic signed [COMP_BITS-1:0] m_out_c2,
    input logic signed [COMP_BITS-1:0] m_out_c3
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_c0) && $stable(m_out_c1)
            && $stable(m_out_c2) && $stable(m_out_c3))
        else $error("result changed while stalled");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Pipeline depth: after reset release, m_valid stays low until a sample could have passed every stage
    a_min_latency: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |-> !m_valid [*5])
        else $error("result appeared faster than the pipeline allows");

    // A receiver that takes results never blocks the input
    a_no_block: assert property (@(posedge aclk)
        m_ready |-> s_ready)
        else $error("input blocked while output is drained");

    // Input stalls only when something is in flight
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid)
        else $error("input stalled with empty output");

endmodule

bind lut_linear_interp_sampler lis_checker #(
    .COMP_BITS (COMP_BITS)
) u_lis_checker (.*);
